// ===== hw/rtl/mbd_pkg.sv =====
// Shared constants for the mipmap 2x2 box downsampler.
// Used by the channel interfaces and the top-level module; no dependencies.
package mbd_pkg;

  localparam int CH_W              = 8;     // one color channel
  localparam int PAIR_W            = CH_W + 1;  // sum of two channel bytes
  localparam int CFG_DATA_W        = 13;    // widest configuration register
  localparam int CFG_INDEX_W       = 1;
  localparam int DEFAULT_MAX_WIDTH = 4096;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int ROW_W             = 12;    // row counter, 0 .. HEIGHT_LIMIT-1
  localparam int NUM_CH            = 4;     // red, green, blue, alpha
  localparam int LINE_W            = NUM_CH * PAIR_W;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 1'b1;

endpackage

// ===== hw/rtl/mbd_pixel_if.sv =====
// Valid/ready channel carrying one RGBA8 source pixel.
// Depends on mbd_pkg for the channel width.
interface mbd_pixel_if import mbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;
  logic [CH_W-1:0] pixel_alpha;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                  input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                  output ready);
endinterface

// ===== hw/rtl/mbd_avg_if.sv =====
// Valid/ready channel carrying one averaged RGBA8 pixel of the next mip level.
// Depends on mbd_pkg for the channel width.
interface mbd_avg_if import mbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] avg_red;
  logic [CH_W-1:0] avg_green;
  logic [CH_W-1:0] avg_blue;
  logic [CH_W-1:0] avg_alpha;
  logic            last_pixel;

  modport source (output valid, avg_red, avg_green, avg_blue, avg_alpha, last_pixel,
                  input ready);
  modport sink   (input valid, avg_red, avg_green, avg_blue, avg_alpha, last_pixel,
                  output ready);
endinterface

// ===== hw/rtl/mbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mipmap_box_downsample.sv =====
// Top level of the mipmap 2x2 box downsampler.
// Depends on mbd_pkg, mbd_pixel_if, mbd_avg_if and mbd_ram.
//
// Usage:
//   Program src_width (index 0) and src_height (index 1) while the block is
//   idle; any write restarts the image at its first pixel. Then stream the
//   source image in raster order on the pixel channel, one RGBA8 pixel per
//   request. Each output pixel is (a + b + c + d + 2) / 4 per channel over its
//   2x2 footprint; the result image is max(1, W/2) x max(1, H/2), odd trailing
//   columns/rows are dropped and a dimension of 1 reuses its single line.
//   Results leave in raster order on the mip channel, with last_pixel set on
//   the final pixel of the halved image. After the last source pixel the
//   block wraps and the next pixel starts a new image of the same size.
//
// Timing: one source pixel per cycle while no result waits on the mip channel. A
//   result passes the stage 1 register, alongside the line store read, and
//   then the output register before it appears on the mip channel.
// Line store: horizontal pair sums of even rows sit in a MAX_WIDTH/2 entry
//   RAM with registered read; it needs no clearing, since every entry is
//   written in an even row before the odd row reads it.
// Reset: clears counters and pipeline valids, both size registers read 1.
// Back-pressure: while the mip channel holds a result that is not taken, the
//   whole pipe freezes and pixel.ready drops in the same cycle.
module mipmap_box_downsample import mbd_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mbd_pixel_if.sink              pixel,
  mbd_avg_if.source              mip
);

  localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1; // column counter
  localparam int UW         = CW + 1;                                 // clamped width
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int HW         = ROW_W + 1;

  // Size registers and position counters
  logic [CFG_DATA_W-1:0] src_width;
  logic [CFG_DATA_W-1:0] src_height;
  logic [CW-1:0]         column_count;
  logic [ROW_W-1:0]      row_count;
  logic [CH_W-1:0]       left_pixel [NUM_CH];

  // Clamped sizes
  logic [UW-1:0] used_w;
  logic [HW-1:0] used_h;
  logic [UW-1:0] w_even;
  logic [HW-1:0] h_even;
  logic          w_one;
  logic          h_one;

  always_comb begin
    if (src_width == '0) begin
      used_w = UW'(1);
    end else if (32'(src_width) > 32'(MAX_WIDTH)) begin
      used_w = UW'(MAX_WIDTH);
    end else begin
      used_w = UW'(src_width);
    end
    if (src_height == '0) begin
      used_h = HW'(1);
    end else if (32'(src_height) > 32'(HEIGHT_LIMIT)) begin
      used_h = HW'(HEIGHT_LIMIT);
    end else begin
      used_h = HW'(src_height);
    end
  end

  assign w_even = {used_w[UW-1:1], 1'b0};
  assign h_even = {used_h[HW-1:1], 1'b0};
  assign w_one  = (used_w == UW'(1));
  assign h_one  = (used_h == HW'(1));

  // Pipeline control: freeze everything while a result waits on the mip channel.
  logic advance;
  logic accept;

  assign advance     = !mip.valid || mip.ready;
  assign pixel.ready = advance;
  assign accept      = pixel.valid && advance;

  logic [CH_W-1:0] pix [NUM_CH];
  assign pix[0] = pixel.pixel_red;
  assign pix[1] = pixel.pixel_green;
  assign pix[2] = pixel.pixel_blue;
  assign pix[3] = pixel.pixel_alpha;

  // Stage 0: horizontal pairing and row decisions
  logic [UW-1:0]     col_inc;
  logic [HW-1:0]     row_inc;
  logic              have_pair;
  logic [PAIR_W-1:0] pair [NUM_CH];
  logic [LINE_W-1:0] pair_flat;
  logic              row_in_range;
  logic              line_write;
  logic              line_read;
  logic              emit;
  logic              last_x;
  logic              last_y;
  logic [AW-1:0]     line_addr;

  assign col_inc = UW'(column_count) + UW'(1);
  assign row_inc = HW'(row_count) + HW'(1);

  always_comb begin
    have_pair = w_one || (column_count[0] && (UW'(column_count) < w_even));
    for (int k = 0; k < NUM_CH; k++) begin
      if (w_one) begin
        pair[k] = {pix[k], 1'b0};
      end else begin
        pair[k] = PAIR_W'(left_pixel[k]) + PAIR_W'(pix[k]);
      end
      pair_flat[k*PAIR_W +: PAIR_W] = pair[k];
    end
  end

  assign row_in_range = HW'(row_count) < h_even;
  assign line_write   = accept && have_pair && !h_one && row_in_range && !row_count[0];
  assign line_read    = accept && have_pair && !h_one && row_in_range && row_count[0];
  assign emit         = have_pair && (h_one || (row_in_range && row_count[0]));
  assign last_x       = w_one || (col_inc == w_even);
  assign last_y       = h_one || (row_inc == h_even);
  assign line_addr    = AW'(column_count >> 1);

  // Counters, size registers and the held left pixel of each pair
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= CFG_DATA_W'(1);
      src_height   <= CFG_DATA_W'(1);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      // restart the image on any size change
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default:        ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_inc == used_w) begin
        column_count <= '0;
        row_count    <= (row_inc == used_h) ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !w_one && !column_count[0]) begin
      for (int k = 0; k < NUM_CH; k++) begin
        left_pixel[k] <= pix[k];
      end
    end
  end

  // Line store of even-row pair sums
  logic [LINE_W-1:0] line_rdata;

  mbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (line_write),
    .waddr (line_addr),
    .wdata (pair_flat),
    .re    (line_read),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  // Stage 1: hold the pair and flags while the line store read completes
  logic              s1_valid;
  logic              s1_single_row;
  logic              s1_last;
  logic [LINE_W-1:0] s1_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_single_row <= h_one;
      s1_last       <= last_x && last_y;
      s1_pair       <= pair_flat;
    end
  end

  // Vertical sum and rounding; a single-row image pairs the row with itself
  logic [LINE_W-1:0] top_flat;
  logic [CH_W+1:0]   vsum [NUM_CH];
  logic [CH_W-1:0]   avg_next [NUM_CH];

  assign top_flat = s1_single_row ? s1_pair : line_rdata;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      vsum[k] = (CH_W+2)'(top_flat[k*PAIR_W +: PAIR_W])
              + (CH_W+2)'(s1_pair[k*PAIR_W +: PAIR_W]) + (CH_W+2)'(2);
      avg_next[k] = vsum[k][CH_W+1:2];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mip.valid <= 1'b0;
    end else if (advance) begin
      mip.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      mip.avg_red    <= avg_next[0];
      mip.avg_green  <= avg_next[1];
      mip.avg_blue   <= avg_next[2];
      mip.avg_alpha  <= avg_next[3];
      mip.last_pixel <= s1_last;
    end
  end

  // Checks
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    UW'(column_count) < used_w)
    else $error("column counter beyond source width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    HW'(row_count) < used_h)
    else $error("row counter beyond source height");

  a_line_one_port: assert property (@(posedge clk) disable iff (rst)
    !(line_write && line_read))
    else $error("line store written and read by the same pixel");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("stage 1 result lost during stall");

  a_emit_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> s1_valid)
    else $error("emitting pixel did not reach stage 1");

endmodule
